@@ hw/rtl/jfhs_pkg.sv @@
// Shared types and constants for the JPEG frame header scanner.
package jfhs_pkg;

    // Marker and fill byte codes
    localparam logic [7:0] BYTE_FILL   = 8'hFF;
    localparam logic [7:0] MARK_SOI    = 8'hD8;
    localparam logic [7:0] MARK_TEM    = 8'h01;
    localparam logic [7:0] MARK_RST0   = 8'hD0;
    localparam logic [7:0] MARK_RST7   = 8'hD7;
    localparam logic [7:0] MARK_EOI    = 8'hD9;
    localparam logic [7:0] MARK_SOF0   = 8'hC0;
    localparam logic [7:0] MARK_SOF_LO = 8'hC0;
    localparam logic [7:0] MARK_SOF_HI = 8'hCF;
    localparam logic [7:0] MARK_DHT    = 8'hC4;
    localparam logic [7:0] MARK_JPG    = 8'hC8;
    localparam logic [7:0] MARK_DAC    = 8'hCC;
    localparam logic [7:0] MARK_SOS    = 8'hDA;

    // Frame header limits
    localparam logic [15:0] LEN_MIN      = 16'd2;
    localparam logic [15:0] LEN_SOF0_MIN = 16'd8;
    localparam logic [7:0]  PRECISION_8  = 8'd8;
    localparam logic [7:0]  COMPS_GREY   = 8'd1;
    localparam logic [7:0]  COMPS_COLOUR = 8'd3;

    // Segment body offsets of the frame header fields
    localparam logic [15:0] OFS_PREC   = 16'd2;
    localparam logic [15:0] OFS_HGT_HI = 16'd3;
    localparam logic [15:0] OFS_HGT_LO = 16'd4;
    localparam logic [15:0] OFS_WID_HI = 16'd5;
    localparam logic [15:0] OFS_WID_LO = 16'd6;
    localparam logic [15:0] OFS_COMPS  = 16'd7;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_SCAN,
        PH_FILL,
        PH_LENHI,
        PH_LENLO,
        PH_BODY,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_TRUNC,
        ST_CORRUPT,
        ST_UNSUP
    } status_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] width;
        logic [15:0] height;
        logic [1:0]  comps;
    } result_t;

endpackage

@@ hw/rtl/jfhs_parse.sv @@
// Byte-wise marker segment parser: holds the scan state and produces verdicts.
module jfhs_parse
    import jfhs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  logic [7:0]  data_byte,
    input  logic        end_of_file,
    output logic        res_valid,
    output result_t     res
);

    phase_t      phase_reg,  phase_next;
    logic        lead_reg,   lead_next;
    logic [7:0]  marker_reg, marker_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] offset_reg, offset_next;
    logic [7:0]  prec_reg,   prec_next;
    logic [15:0] height_reg, height_next;
    logic [15:0] width_reg,  width_next;
    logic [7:0]  comps_reg,  comps_next;

    logic        verdict;
    status_t     verdict_status;
    logic [15:0] len_full;
    logic [15:0] res_width;
    logic [15:0] res_height;
    logic [1:0]  res_comps;

    // Verdict on a complete segment: bit 2 says a verdict exists
    function automatic logic [2:0] judge(
        input logic [7:0]  mk,
        input logic [15:0] len,
        input logic [7:0]  prec,
        input logic [15:0] hgt,
        input logic [15:0] wid,
        input logic [7:0]  cmp
    );
        logic is_sof;
        logic bad;
        is_sof = (mk >= MARK_SOF_LO) && (mk <= MARK_SOF_HI) && (mk != MARK_DHT)
                 && (mk != MARK_JPG) && (mk != MARK_DAC);
        bad = (len < LEN_SOF0_MIN) || (prec != PRECISION_8)
              || ((cmp != COMPS_GREY) && (cmp != COMPS_COLOUR))
              || (wid == 16'd0) || (hgt == 16'd0);
        if (is_sof)
        begin
            if (mk != MARK_SOF0)
                judge = {1'b1, ST_UNSUP};
            else if (bad)
                judge = {1'b1, ST_CORRUPT};
            else
                judge = {1'b1, ST_OK};
        end
        else if (mk == MARK_SOS)
            judge = {1'b1, ST_CORRUPT};
        else
            judge = 3'b000;
    endfunction

    assign len_full = {length_reg[15:8], data_byte};

    // Next state and verdict for the byte on the input
    always_comb
    begin
        logic [2:0] j;
        phase_next     = phase_reg;
        lead_next      = lead_reg;
        marker_next    = marker_reg;
        length_next    = length_reg;
        offset_next    = offset_reg;
        prec_next      = prec_reg;
        height_next    = height_reg;
        width_next     = width_reg;
        comps_next     = comps_reg;
        verdict        = 1'b0;
        verdict_status = ST_OK;
        j              = 3'b000;

        unique case (phase_reg)
            PH_LEAD:
            begin
                if (lead_reg)
                    phase_next = PH_SCAN;
                else
                    lead_next = 1'b1;
            end
            PH_SCAN:
            begin
                if (data_byte == BYTE_FILL)
                    phase_next = PH_FILL;
            end
            PH_FILL:
            begin
                if (data_byte != BYTE_FILL)
                begin
                    marker_next = data_byte;
                    if ((data_byte == MARK_SOI) || (data_byte == MARK_TEM)
                        || ((data_byte >= MARK_RST0) && (data_byte <= MARK_RST7)))
                        phase_next = PH_SCAN;
                    else if (data_byte == MARK_EOI)
                    begin
                        verdict        = 1'b1;
                        verdict_status = ST_CORRUPT;
                    end
                    else
                        phase_next = PH_LENHI;
                end
            end
            PH_LENHI:
            begin
                length_next = {data_byte, 8'h00};
                phase_next  = PH_LENLO;
            end
            PH_LENLO:
            begin
                length_next = len_full;
                if (len_full < LEN_MIN)
                begin
                    verdict        = 1'b1;
                    verdict_status = ST_CORRUPT;
                end
                else
                begin
                    offset_next = OFS_PREC;
                    if (len_full == LEN_MIN)
                    begin
                        j = judge(marker_reg, len_full, prec_reg, height_reg,
                                  width_reg, comps_reg);
                        verdict        = j[2];
                        verdict_status = status_t'(j[1:0]);
                        if (!j[2])
                            phase_next = PH_SCAN;
                    end
                    else
                        phase_next = PH_BODY;
                end
            end
            PH_BODY:
            begin
                case (offset_reg)
                    OFS_PREC:   prec_next          = data_byte;
                    OFS_HGT_HI: height_next        = {data_byte, 8'h00};
                    OFS_HGT_LO: height_next[7:0]   = data_byte;
                    OFS_WID_HI: width_next         = {data_byte, 8'h00};
                    OFS_WID_LO: width_next[7:0]    = data_byte;
                    OFS_COMPS:  comps_next         = data_byte;
                    default:    ;
                endcase
                offset_next = offset_reg + 16'd1;
                if (offset_next >= length_reg)
                begin
                    j = judge(marker_reg, length_reg, prec_next, height_next,
                              width_next, comps_next);
                    verdict        = j[2];
                    verdict_status = status_t'(j[1:0]);
                    if (!j[2])
                        phase_next = PH_SCAN;
                end
            end
            PH_DONE:
            begin
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase

        // Stream ended with nothing decided
        if (!verdict && end_of_file && (phase_reg != PH_DONE))
        begin
            verdict        = 1'b1;
            verdict_status = ST_TRUNC;
        end

        if (verdict)
            phase_next = PH_DONE;

        // Keep the frame fields of this byte before the final byte clears them
        res_width  = width_next;
        res_height = height_next;
        res_comps  = comps_next[1:0];

        // Return to start after the final byte
        if (end_of_file)
        begin
            phase_next  = PH_LEAD;
            lead_next   = 1'b0;
            marker_next = 8'h00;
            length_next = 16'd0;
            offset_next = 16'd0;
            prec_next   = 8'h00;
            height_next = 16'd0;
            width_next  = 16'd0;
            comps_next  = 8'h00;
        end
    end

    // Result payload: fields only on a good frame header
    always_comb
    begin
        res_valid  = take && verdict;
        res.status = verdict_status;
        if (verdict_status == ST_OK)
        begin
            res.width  = res_width;
            res.height = res_height;
            res.comps  = res_comps;
        end
        else
        begin
            res.width  = 16'd0;
            res.height = 16'd0;
            res.comps  = 2'd0;
        end
    end

    // Advance the scan state on each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_LEAD;
            lead_reg   <= 1'b0;
            marker_reg <= 8'h00;
            length_reg <= 16'd0;
            offset_reg <= 16'd0;
            prec_reg   <= 8'h00;
            height_reg <= 16'd0;
            width_reg  <= 16'd0;
            comps_reg  <= 8'h00;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            lead_reg   <= lead_next;
            marker_reg <= marker_next;
            length_reg <= length_next;
            offset_reg <= offset_next;
            prec_reg   <= prec_next;
            height_reg <= height_next;
            width_reg  <= width_next;
            comps_reg  <= comps_next;
        end
    end

endmodule

@@ hw/rtl/jpeg_frame_header_scan.sv @@
// Top level of the JPEG frame header scanner: parser plus result buffering.
// A result is registered in the result register, or in the skid register while an undrained result waits.
// One byte per cycle while in_stall is low; each byte taken updates the scan state registers.
// A result register and a skid register hold results; in_stall rises only while
// the skid register is occupied. Exactly one result per stream.
// Reset (rst_n low, asynchronous) returns the scan to the start of a stream.
module jpeg_frame_header_scan
    import jfhs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_file,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [15:0] image_width,
    output logic [15:0] image_height,
    output logic [1:0]  component_count
);

    logic    take;
    logic    res_valid;
    result_t res;
    logic    drain;

    logic    out_valid_reg;
    result_t out_reg;
    logic    skid_valid_reg;
    result_t skid_reg;

    assign in_stall = skid_valid_reg;
    assign take     = in_valid && !skid_valid_reg;
    assign drain    = out_valid_reg && !out_stall;

    jfhs_parse u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .data_byte   (data_byte),
        .end_of_file (end_of_file),
        .res_valid   (res_valid),
        .res         (res)
    );

    // Output and skid valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (drain)
                skid_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            if (out_valid_reg && !drain)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (drain)
            out_valid_reg <= 1'b0;
    end

    // Output and skid payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (drain)
                out_reg <= skid_reg;
        end
        else if (res_valid)
        begin
            if (out_valid_reg && !drain)
                skid_reg <= res;
            else
                out_reg <= res;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_reg.status;
    assign image_width     = out_reg.width;
    assign image_height    = out_reg.height;
    assign component_count = out_reg.comps;

endmodule

@@ hw/rtl/jfhs_checker.sv @@
// Port-level checks for the JPEG frame header scanner, bound to the top level.
module jfhs_checker
    import jfhs_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic [15:0] image_width,
    input logic [15:0] image_height,
    input logic [1:0]  component_count
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
            && $stable(image_width) && $stable(image_height)
            && $stable(component_count))
        else $error("stalled result changed");

    // Input stalls only behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result waiting");

    // Fields are zero unless the frame header is good
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> (image_width == 16'd0)
            && (image_height == 16'd0) && (component_count == 2'd0))
        else $error("non-zero fields on a failed result");

    // A good frame header has sane fields
    a_ok_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_OK) |-> (image_width != 16'd0)
            && (image_height != 16'd0)
            && ((component_count == 2'd1) || (component_count == 2'd3)))
        else $error("bad fields on a good result");

endmodule

bind jpeg_frame_header_scan jfhs_checker u_jfhs_checker (.*);

@@ verif/tb_jpeg_frame_header_scan.sv @@
// Testbench for the JPEG frame header scanner: directed and random byte streams, checked per result.
module tb_jpeg_frame_header_scan;
    import jfhs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT    = 200;
    localparam int DRAIN_CYCLES  = 4;
    localparam int RANDOM_TARGET = 1150;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        end_of_file = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [1:0]  component_count;

    // Scanner state as the testbench sees it
    phase_t      scan_phase;
    logic        lead_seen;
    logic [7:0]  seg_marker;
    logic [15:0] seg_len;
    logic [15:0] seg_ofs;
    logic [7:0]  frame_prec;
    logic [15:0] frame_height;
    logic [15:0] frame_width;
    logic [7:0]  frame_comps;
    logic        decided;

    result_t     pending_results[$];
    logic [7:0]  stream_bytes[$];
    int          mismatch_count = 0;
    int          bytes_sent = 0;
    int          idle_cycles = 0;
    int          out_hold = 0;
    bit          calm_mode = 1'b0;

    jpeg_frame_header_scan i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .data_byte       (data_byte),
        .end_of_file     (end_of_file),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .image_width     (image_width),
        .image_height    (image_height),
        .component_count (component_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Return the scan state to the start of a stream
    function automatic void clear_scan_state();
        scan_phase   = PH_LEAD;
        lead_seen    = 1'b0;
        seg_marker   = 8'h00;
        seg_len      = 16'h0000;
        seg_ofs      = 16'h0000;
        frame_prec   = 8'h00;
        frame_height = 16'h0000;
        frame_width  = 16'h0000;
        frame_comps  = 8'h00;
        decided      = 1'b0;
    endfunction

    // Judge a completed segment: a status, or -1 when it is skipped
    function automatic int segment_verdict();
        if (seg_marker >= MARK_SOF_LO && seg_marker <= MARK_SOF_HI && seg_marker != MARK_DHT &&
            seg_marker != MARK_JPG && seg_marker != MARK_DAC)
        begin
            if (seg_marker != MARK_SOF0)
                return ST_UNSUP;
            if (seg_len < LEN_SOF0_MIN)
                return ST_CORRUPT;
            if (frame_prec != PRECISION_8 ||
                (frame_comps != COMPS_GREY && frame_comps != COMPS_COLOUR) ||
                frame_width == 16'h0000 || frame_height == 16'h0000)
                return ST_CORRUPT;
            return ST_OK;
        end
        if (seg_marker == MARK_SOS)
            return ST_CORRUPT;
        return -1;
    endfunction

    // Advance the scan by one byte and queue the result it decides, if any
    function automatic void scan_byte(input logic [7:0] b, input logic eof);
        int      verdict;
        result_t res;
        verdict = -1;
        case (scan_phase)
            PH_LEAD:
            begin
                if (lead_seen)
                    scan_phase = PH_SCAN;
                else
                    lead_seen = 1'b1;
            end
            PH_SCAN:
            begin
                if (b == BYTE_FILL)
                    scan_phase = PH_FILL;
            end
            PH_FILL:
            begin
                if (b != BYTE_FILL)
                begin
                    seg_marker = b;
                    if (b == MARK_SOI || b == MARK_TEM || (b >= MARK_RST0 && b <= MARK_RST7))
                        scan_phase = PH_SCAN;
                    else if (b == MARK_EOI)
                        verdict = ST_CORRUPT;
                    else
                        scan_phase = PH_LENHI;
                end
            end
            PH_LENHI:
            begin
                seg_len    = {b, 8'h00};
                scan_phase = PH_LENLO;
            end
            PH_LENLO:
            begin
                seg_len = seg_len | {8'h00, b};
                if (seg_len < LEN_MIN)
                    verdict = ST_CORRUPT;
                else
                begin
                    seg_ofs = LEN_MIN;
                    if (seg_len == LEN_MIN)
                    begin
                        verdict = segment_verdict();
                        if (verdict < 0)
                            scan_phase = PH_SCAN;
                    end
                    else
                        scan_phase = PH_BODY;
                end
            end
            PH_BODY:
            begin
                case (seg_ofs)
                    OFS_PREC:   frame_prec = b;
                    OFS_HGT_HI: frame_height = {b, 8'h00};
                    OFS_HGT_LO: frame_height = frame_height | {8'h00, b};
                    OFS_WID_HI: frame_width = {b, 8'h00};
                    OFS_WID_LO: frame_width = frame_width | {8'h00, b};
                    OFS_COMPS:  frame_comps = b;
                    default: ;
                endcase
                seg_ofs = seg_ofs + 16'd1;
                if (seg_ofs >= seg_len)
                begin
                    verdict = segment_verdict();
                    if (verdict < 0)
                        scan_phase = PH_SCAN;
                end
            end
            default: ;
        endcase

        if (verdict < 0 && eof && !decided)
            verdict = ST_TRUNC;

        if (verdict >= 0)
        begin
            res.status = status_t'(verdict[1:0]);
            if (res.status == ST_OK)
            begin
                res.width  = frame_width;
                res.height = frame_height;
                res.comps  = frame_comps[1:0];
            end
            else
            begin
                res.width  = 16'h0000;
                res.height = 16'h0000;
                res.comps  = 2'd0;
            end
            pending_results.push_back(res);
            decided    = 1'b1;
            scan_phase = PH_DONE;
        end

        if (eof)
            clear_scan_state();
    endfunction

    // Offer one byte after a random gap (none in calm mode) and hold it until the transfer
    task automatic send_byte(input logic [7:0] b, input logic eof);
        int gap;
        gap = calm_mode ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        data_byte   <= b;
        end_of_file <= eof;
        do
            @(posedge clk);
        while (in_stall);
        scan_byte(b, eof);
        bytes_sent++;
    endtask

    // Send the buffered stream, flagging its last byte
    task automatic send_stream();
        for (int i = 0; i < stream_bytes.size(); i++)
            send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
    endtask

    // Drop valid and hold until every expected result has arrived
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Build one random stream, mostly well-formed segments with random content
    task automatic build_random_stream();
        int         pick;
        int         seg_count;
        int         body_len;
        int         cut;
        logic [7:0] mk;
        logic [7:0] comps;
        logic [7:0] prec;
        logic [15:0] len;
        logic [15:0] hgt;
        logic [15:0] wid;
        logic [7:0] pb;
        stream_bytes.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            // Noise: bytes with no structure at all
            repeat ($urandom_range(1, 40)) stream_bytes.push_back(8'($urandom));
            return;
        end
        if ($urandom_range(0, 1) == 0)
        begin
            stream_bytes.push_back(BYTE_FILL);
            stream_bytes.push_back(MARK_SOI);
        end
        else
        begin
            stream_bytes.push_back(8'($urandom));
            stream_bytes.push_back(8'($urandom));
        end
        seg_count = $urandom_range(1, 4);
        for (int s = 0; s < seg_count; s++)
        begin
            repeat ($urandom_range(0, 2)) stream_bytes.push_back(8'($urandom_range(0, 254)));
            repeat ($urandom_range(1, 3)) stream_bytes.push_back(BYTE_FILL);
            pick = $urandom_range(0, 15);
            if (pick <= 4)
                mk = MARK_SOF0;
            else if (pick == 5)
            begin
                do
                    mk = 8'(MARK_SOF_LO + $urandom_range(1, 15));
                while (mk == MARK_DHT || mk == MARK_JPG || mk == MARK_DAC);
            end
            else if (pick == 6)
            begin
                case ($urandom_range(0, 2))
                    0: mk = MARK_DHT;
                    1: mk = MARK_JPG;
                    default: mk = MARK_DAC;
                endcase
            end
            else if (pick == 7)
                mk = MARK_SOS;
            else if (pick == 8)
                mk = MARK_EOI;
            else if (pick == 9)
                mk = ($urandom_range(0, 1) == 0) ? MARK_SOI : MARK_TEM;
            else if (pick == 10)
                mk = 8'(MARK_RST0 + $urandom_range(0, 7));
            else if (pick <= 13)
                mk = 8'(8'hE0 + $urandom_range(0, 15));
            else
                mk = 8'($urandom);
            stream_bytes.push_back(mk);
            if (pick >= 8 && pick <= 10)
                continue;

            // Frame header fields, mostly legal
            prec  = ($urandom_range(0, 5) == 0) ? 8'($urandom) : PRECISION_8;
            comps = ($urandom_range(0, 5) == 0) ? 8'($urandom) :
                    (($urandom_range(0, 1) == 0) ? COMPS_GREY : COMPS_COLOUR);
            hgt   = ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom_range(1, 65535));
            wid   = ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom_range(1, 65535));
            case ($urandom_range(0, 9))
                0: len = 16'($urandom_range(0, 1));
                1: len = 16'($urandom);
                2: len = 16'($urandom_range(2, 9));
                default: len = (mk == MARK_SOF0) ? 16'(8 + 3 * $urandom_range(0, 3)) :
                                                   16'($urandom_range(2, 12));
            endcase
            stream_bytes.push_back(len[15:8]);
            stream_bytes.push_back(len[7:0]);
            body_len = (len < 2) ? 0 : ((len - 2 > 24) ? 24 : len - 2);
            for (int ofs = 2; ofs < body_len + 2; ofs++)
            begin
                case (ofs)
                    2: pb = prec;
                    3: pb = hgt[15:8];
                    4: pb = hgt[7:0];
                    5: pb = wid[15:8];
                    6: pb = wid[7:0];
                    7: pb = comps;
                    default: pb = 8'($urandom);
                endcase
                stream_bytes.push_back(pb);
            end
        end
        repeat ($urandom_range(0, 3)) stream_bytes.push_back(8'($urandom));
        // Cut some streams short so that they may end undecided
        if ($urandom_range(0, 4) == 0 && stream_bytes.size() > 1)
        begin
            cut = $urandom_range(1, stream_bytes.size());
            while (stream_bytes.size() > cut)
                void'(stream_bytes.pop_back());
        end
    endtask

    // Truncated lead-in, end-of-image marker and a length below two
    task automatic test_short_streams();
        stream_bytes = '{8'hFF};
        send_stream();
        stream_bytes = '{8'h00, 8'hFF, BYTE_FILL, MARK_EOI};
        send_stream();
        stream_bytes = '{BYTE_FILL, MARK_SOI, BYTE_FILL, 8'hE0, 8'h00, 8'h01};
        send_stream();
    endtask

    // Baseline frame with junk, fill, a restart marker and a byte after the verdict
    task automatic test_baseline_frame();
        stream_bytes = '{BYTE_FILL, MARK_SOI, 8'h7A, BYTE_FILL, BYTE_FILL, MARK_RST0,
                         BYTE_FILL, MARK_SOF0, 8'h00, 8'h08, PRECISION_8, 8'hFF, 8'hFF,
                         8'hFF, 8'hFF, COMPS_COLOUR, 8'h00};
        send_stream();
    endtask

    // Random streams until the byte count reaches the target
    task automatic test_random_streams(input int target);
        while (bytes_sent < target)
        begin
            calm_mode = ($urandom_range(0, 7) == 0);
            build_random_stream();
            send_stream();
        end
        calm_mode = 1'b0;
    endtask

    // Send one stream, then hold the sender until the block has emptied
    task automatic test_pause_until_drained();
        build_random_stream();
        send_stream();
        wait_drained();
    endtask

    // Check each result transfer and draw the receiver's stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result status %0d width %0d height %0d comps %0d",
                         $time, status, image_width, image_height, component_count);
                mismatch_count++;
            end
            else
            begin
                if (status != pending_results[0].status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             pending_results[0].status, status);
                    mismatch_count++;
                end
                if (image_width != pending_results[0].width)
                begin
                    $display("%0t: image_width expected %0d actual %0d", $time,
                             pending_results[0].width, image_width);
                    mismatch_count++;
                end
                if (image_height != pending_results[0].height)
                begin
                    $display("%0t: image_height expected %0d actual %0d", $time,
                             pending_results[0].height, image_height);
                    mismatch_count++;
                end
                if (component_count != pending_results[0].comps)
                begin
                    $display("%0t: component_count expected %0d actual %0d", $time,
                             pending_results[0].comps, component_count);
                    mismatch_count++;
                end
                void'(pending_results.pop_front());
            end
            out_hold = calm_mode ? 0 : $urandom_range(0, 5);
            out_stall <= (out_hold != 0);
        end
        else if (out_hold > 0)
        begin
            out_hold--;
            out_stall <= (out_hold != 0);
        end
    end

    // End the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("jpeg_frame_header_scan: mismatch");
            $finish;
        end
    end

    initial
    begin
        clear_scan_state();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_short_streams();
        test_baseline_frame();
        test_random_streams(RANDOM_TARGET / 2);
        test_pause_until_drained();
        test_random_streams(RANDOM_TARGET);
        wait_drained();
        if (mismatch_count == 0)
            $display("jpeg_frame_header_scan: match");
        else
            $display("jpeg_frame_header_scan: mismatch");
        $finish;
    end

endmodule
